### src/pwia_pkg.sv
// Shared types, widths and register codes for the averaging PID controller.
package pwia_pkg;

    // Default depth of the measurement averaging ring.
    localparam int SAMPLES_DEF = 3;

    // Fixed field widths.
    localparam int IN_W     = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int SUM_W    = 48;
    localparam int GAIN_W   = 32;
    localparam int DRIVE_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_DT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_OVER_DT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP     = 3'd5;

    // Depth of the queue between the error front end and the PID back end.
    localparam int QUEUE_DEPTH = 4;

    // Saturation limits of the integral.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic signed [ERR_W-1:0] t_err;

    // Configuration register set seen by the back end.
    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki_dt;
        logic signed [GAIN_W-1:0]  kd_over_dt;
        logic signed [DRIVE_W-1:0] out_max;
        logic signed [DRIVE_W-1:0] out_min;
        logic                      windup_protect;
    } t_cfg;

    // Back end sequencer steps.
    typedef enum logic [1:0] {
        BK_GATE,
        BK_MUL,
        BK_SUM,
        BK_CLAMP
    } t_back_state;

endpackage

### src/pwia_queue.sv
// Small register queue that decouples the error front end from the PID back end.
module pwia_queue import pwia_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int WIDTH = ERR_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### src/pwia_front.sv
// Front end: keeps the sample ring and running total, averages it and forms the error.
module pwia_front import pwia_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [IN_W-1:0] i_setpoint,
    input  logic signed [IN_W-1:0] i_measured,
    output logic                   o_push,
    output t_err                   o_err,
    input  logic                   i_full
);

    localparam int SLOT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int TOT_W   = IN_W + $clog2(SAMPLES);
    localparam int RSH     = TOT_W;
    localparam int RECIP_W = RSH + 1;
    localparam int PROD_W  = TOT_W + RECIP_W;
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SAMPLES - 1);
    localparam logic [TOT_W-1:0]   N_VAL     = TOT_W'(SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'((longint'(1) << RSH) / longint'(SAMPLES));

    // Ring and running total.
    logic signed [IN_W-1:0]  r_ring [SAMPLES];
    logic [SLOT_W-1:0]       r_slot;
    logic signed [TOT_W-1:0] r_total;
    logic signed [TOT_W-1:0] n_total;

    // Stage registers.
    logic                    r_f1_valid;
    logic signed [IN_W-1:0]  r_f1_sp;
    logic signed [TOT_W-1:0] r_f1_total;

    logic                    r_f2_valid;
    logic signed [IN_W-1:0]  r_f2_sp;
    logic [TOT_W-1:0]        r_f2_mag;
    logic [TOT_W-1:0]        r_f2_q0;
    logic                    r_f2_neg;

    logic                    r_f3_valid;
    logic signed [IN_W-1:0]  r_f3_sp;
    logic [IN_W-1:0]         r_f3_q;
    logic                    r_f3_neg;

    logic                    adv;
    logic                    accept;
    logic [TOT_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [TOT_W-1:0]        rem;
    logic [TOT_W-1:0]        q;
    t_err                    avg_mag;
    t_err                    avg;

    // The whole front moves together unless the last stage cannot enter the queue.
    assign adv     = !(r_f3_valid && i_full);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;
    assign o_push  = r_f3_valid && !i_full;

    // New total replaces the oldest sample with the incoming one.
    assign n_total = r_total - TOT_W'(r_ring[r_slot]) + TOT_W'(i_measured);

    // Magnitude times the scaled reciprocal gives the quotient or one less.
    assign mag  = r_f1_total[TOT_W-1] ? TOT_W'(-r_f1_total) : TOT_W'(r_f1_total);
    assign prod = PROD_W'(mag) * PROD_W'(RECIP);

    // One correction step brings the quotient to its exact value.
    assign rem = r_f2_mag - TOT_W'(r_f2_q0 * N_VAL);
    assign q   = (rem >= N_VAL) ? r_f2_q0 + 1'b1 : r_f2_q0;

    // Restore the sign (truncation toward zero) and subtract from the setpoint.
    assign avg_mag = $signed({1'b0, r_f3_q});
    assign avg     = r_f3_neg ? -avg_mag : avg_mag;
    assign o_err   = ERR_W'(r_f3_sp) - avg;

    // Ring state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SAMPLES; k++) begin
                r_ring[k] <= '0;
            end
            r_slot  <= '0;
            r_total <= '0;
        end else if (accept) begin
            r_ring[r_slot] <= i_measured;
            r_slot         <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            r_total        <= n_total;
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (adv) begin
            r_f1_valid <= accept;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_sp    <= i_setpoint;
            r_f1_total <= n_total;
            r_f2_sp    <= r_f1_sp;
            r_f2_mag   <= mag;
            r_f2_q0    <= prod[RSH +: TOT_W];
            r_f2_neg   <= r_f1_total[TOT_W-1];
            r_f3_sp    <= r_f2_sp;
            r_f3_q     <= q[IN_W-1:0];
            r_f3_neg   <= r_f2_neg;
        end
    end

endmodule

### src/pwia_back.sv
// Back end: integral gate and update, gain products, sum, shift, clamp and output beat.
module pwia_back import pwia_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_empty,
    input  t_err                      i_err,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DRIVE_W-1:0] o_drive
);

    localparam int PLO_W = GAIN_W + 25;
    localparam int PHI_W = GAIN_W + 24;
    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PD_W  = GAIN_W + DIFF_W;
    localparam int LOW_W = PLO_W + 1;
    localparam int SH_W  = PHI_W + 10;

    t_back_state r_state;
    t_back_state n_state;

    // Controller state.
    logic signed [SUM_W-1:0]   r_es;
    t_err                      r_prev_err;
    logic signed [DRIVE_W-1:0] r_prev_drive;

    // Working registers.
    t_err                      r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PLO_W-1:0]   r_p_lo;
    logic signed [PHI_W-1:0]   r_p_hi;
    logic signed [PP_W-1:0]    r_p_p;
    logic signed [PD_W-1:0]    r_p_d;
    logic signed [LOW_W-1:0]   r_low;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;

    logic                      gate;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SH_W-1:0]    shifted;
    logic signed [SH_W-1:0]    max_ext;
    logic signed [SH_W-1:0]    min_ext;
    logic signed [DRIVE_W-1:0] drive;
    logic                      take;
    logic                      done;

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    // With windup protection on, integration stops when the last drive sits at the limit.
    assign gate = !i_cfg.windup_protect
               || ((i_cfg.out_min < r_prev_drive) && i_err[ERR_W-1])
               || ((i_cfg.out_max > r_prev_drive) && !i_err[ERR_W-1] && (i_err != '0));

    // Saturating integral update.
    assign sum_wide = $signed({r_es[SUM_W-1], r_es})
                    + $signed({{(SUM_W+1-ERR_W){i_err[ERR_W-1]}}, i_err});
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign diff = DIFF_W'(i_err) - DIFF_W'(r_prev_err);

    // The high integral product carries weight 2^24, so it enters the shifted sum at 2^8.
    assign shifted = $signed({{2{r_p_hi[PHI_W-1]}}, r_p_hi, 8'b0})
                   + $signed({{(SH_W-LOW_W+16){r_low[LOW_W-1]}}, r_low[LOW_W-1:16]});
    assign max_ext = $signed({{(SH_W-DRIVE_W){i_cfg.out_max[DRIVE_W-1]}}, i_cfg.out_max});
    assign min_ext = $signed({{(SH_W-DRIVE_W){i_cfg.out_min[DRIVE_W-1]}}, i_cfg.out_min});

    // Upper limit first, then lower.
    always_comb begin
        if (shifted > max_ext) begin
            drive = i_cfg.out_max;
        end else if (shifted < min_ext) begin
            drive = i_cfg.out_min;
        end else begin
            drive = shifted[DRIVE_W-1:0];
        end
    end

    assign take = (r_state == BK_GATE) && !i_empty;
    assign done = (r_state == BK_CLAMP) && (!r_out_valid || !i_stall);

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_GATE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next step and queue pop.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_GATE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_SUM;
            end
            BK_SUM: begin
                n_state = BK_CLAMP;
            end
            BK_CLAMP: begin
                if (done) begin
                    n_state = BK_GATE;
                end
            end
            default: begin
                n_state = BK_GATE;
            end
        endcase
    end

    // Controller state and output beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es         <= '0;
            r_prev_err   <= '0;
            r_prev_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                if (gate) begin
                    r_es <= sum_sat;
                end
                r_prev_err <= i_err;
            end
            if (done) begin
                r_prev_drive <= drive;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_err  <= i_err;
            r_diff <= diff;
        end
        if (r_state == BK_MUL) begin
            r_p_lo <= PLO_W'(i_cfg.ki_dt) * PLO_W'($signed({1'b0, r_es[23:0]}));
            r_p_hi <= PHI_W'(i_cfg.ki_dt) * PHI_W'($signed(r_es[SUM_W-1:24]));
            r_p_p  <= PP_W'(i_cfg.kp) * PP_W'(r_err);
            r_p_d  <= PD_W'(i_cfg.kd_over_dt) * PD_W'(r_diff);
        end
        if (r_state == BK_SUM) begin
            r_low <= LOW_W'(r_p_lo) + LOW_W'(r_p_p) + LOW_W'(r_p_d);
        end
        if (done) begin
            r_drive <= drive;
        end
    end

endmodule

### src/pid_with_input_average.sv
// Top level of the PID controller with a moving-average input filter.
//
//  Channel  | Handshake              | Beat contents
//  ---------+------------------------+------------------------------------
//  input    | i_valid / o_stall      | i_setpoint, i_measured
//  output   | o_valid / i_stall      | o_drive
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The front end takes one beat per cycle while o_stall is low and forms the error
// through its registered stages f1, f2 and f3. The back end takes one item at a time
// and steps it through gate, multiply, sum and clamp before it takes another, because
// the integral gate of an item waits for the clamped drive of the one before.
// Reset clears the ring, the running total, the integral and the history.
// o_stall rises only when the error queue is full and the last front stage is held;
// i_stall holds the output register, and the back end waits in its final step.
module pid_with_input_average import pwia_pkg::*; #(
    parameter int SAMPLES = SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [IN_W-1:0]    i_setpoint,
    input  logic signed [IN_W-1:0]    i_measured,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DRIVE_W-1:0] o_drive,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_err q_in;
    t_err q_out;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp             <= '0;
            r_cfg.ki_dt          <= '0;
            r_cfg.kd_over_dt     <= '0;
            r_cfg.out_max        <= 16'sh7FFF;
            r_cfg.out_min        <= 16'sh8000;
            r_cfg.windup_protect <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KP:         r_cfg.kp             <= $signed(i_cfg_data);
                REG_KI_DT:      r_cfg.ki_dt          <= $signed(i_cfg_data);
                REG_KD_OVER_DT: r_cfg.kd_over_dt     <= $signed(i_cfg_data);
                REG_OUT_MAX:    r_cfg.out_max        <= $signed(i_cfg_data[DRIVE_W-1:0]);
                REG_OUT_MIN:    r_cfg.out_min        <= $signed(i_cfg_data[DRIVE_W-1:0]);
                REG_WINDUP:     r_cfg.windup_protect <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Error front end.
    pwia_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_setpoint (i_setpoint),
        .i_measured (i_measured),
        .o_push     (q_push),
        .o_err      (q_in),
        .i_full     (q_full)
    );

    // Error queue.
    pwia_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ERR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // PID back end.
    pwia_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_err   (q_out),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_drive (o_drive)
    );

endmodule
